@@ rtl/core/rsa_modular_exponentiation_defines.svh @@
// Assertion macros shared by the modular exponentiation RTL.
// Included by the top level; depends on nothing else.
`ifndef RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_DEFINES_SVH

// Property holds in the same cycle as its antecedent.
`define RME_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rme assertion failed");

// Property holds in the cycle after its antecedent.
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rme assertion failed");

`endif

@@ rtl/core/rme_pkg.sv @@
// Shared types and constants of the modular exponentiation block.
// Used by rme_modmul and rsa_modular_exponentiation; depends on nothing.
`default_nettype none

package rme_pkg;

  localparam int unsigned DataWidth = 31;
  localparam int unsigned CntWidth  = $clog2(DataWidth);

  typedef logic [DataWidth-1:0] word_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODULUS  = 2'd0;
  localparam logic [1:0] CFG_PUB_EXP  = 2'd1;
  localparam logic [1:0] CFG_PRIV_EXP = 2'd2;

  // Request to the serial modular multiplier.
  typedef struct packed {
    logic  start;
    word_t op_a;
    word_t op_b;
    word_t modulus;
  } mm_req_t;

  // Response from the serial modular multiplier.
  typedef struct packed {
    logic  done;
    word_t product;
  } mm_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/rme_modmul.sv @@
// Bit-serial modular multiplier, (a * b) mod m, one bit of b per cycle.
// Depends on rme_pkg.
`default_nettype none

module rme_modmul (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rme_pkg::mm_req_t req_i,
  output rme_pkg::mm_rsp_t     rsp_o
);
  import rme_pkg::*;

  logic                acc_en;
  word_t               acc_q, acc_d;
  word_t               a_q, b_q, m_q;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                run_q, run_d;
  logic                done_q, done_d;

  logic [DataWidth:0]  m_ext, dbl, dbl_r, sum, sum_r;

  // One step: double and reduce, then add a when the bit of b is set and reduce.
  // The accumulator stays below m, so one subtraction suffices each time.
  always_comb begin
    m_ext = {1'b0, m_q};
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum   = dbl_r + {1'b0, a_q};
    sum_r = (sum >= m_ext) ? sum - m_ext : sum;
  end

  always_comb begin
    acc_en = 1'b0;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_en = 1'b1;
      acc_d  = '0;
      cnt_d  = CntWidth'(DataWidth - 1);
      run_d  = 1'b1;
    end else if (run_q) begin
      acc_en = 1'b1;
      acc_d  = b_q[DataWidth-1] ? sum_r[DataWidth-1:0] : dbl_r[DataWidth-1:0];
      cnt_d  = cnt_q - CntWidth'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_en) begin
      acc_q <= acc_d;
    end
    if (req_i.start) begin
      a_q <= req_i.op_a;
      b_q <= req_i.op_b;
      m_q <= req_i.modulus;
    end else if (run_q) begin
      b_q <= {b_q[DataWidth-2:0], 1'b0};
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

`default_nettype wire

@@ rtl/core/rsa_modular_exponentiation.sv @@
// Top level of the modular exponentiation block: registers, sequencer, output.
// Depends on rme_pkg, rme_modmul and rsa_modular_exponentiation_defines.svh.
`default_nettype none
`include "rsa_modular_exponentiation_defines.svh"

// Usage:
// A request is taken at a rising edge with start_i high and busy_o low; it
// carries mode_i (0 selects the public exponent, 1 the private one) and
// value_i. The block returns value_i to the selected exponent modulo the
// modulus register on result_o, marked by result_valid_o for one cycle.
// The receiver cannot stall; it must take the result in that cycle.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i at
// any edge with cfg_we_i high (index 0 modulus, 1 public exponent,
// 2 private exponent, other indexes ignored); write only while idle.
// A zero exponent gives 1, even for modulus 1; a zero modulus with a nonzero
// exponent gives 0. Both show the strobe in the cycle after the accepting
// edge, and busy_o never rises. Otherwise the value is first reduced, then
// the exponent is walked from bit 0 up to its top set bit. Each multiplier
// pass has 31 steps. The bit-serial modular multiplier takes one multiplier
// bit per cycle and is shared by all reductions, multiplications and
// squarings. busy_o falls in the cycle that shows the strobe, so the next
// request can be taken at the edge that ends it. Reset restores modulus 1
// and both exponents 0, and leaves the block idle.
module rsa_modular_exponentiation (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic                       mode_i,
  input  wire logic [rme_pkg::DataWidth-1:0] value_i,
  output logic [rme_pkg::DataWidth-1:0]   result_o,
  output logic                            result_valid_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [rme_pkg::DataWidth-1:0] cfg_data_i
);
  import rme_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_BIT    = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_SQR    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  word_t mod_q, pub_q, priv_q;

  // Working registers: remaining exponent bits, running result and base.
  word_t exp_q, exp_d;
  word_t res_q, res_d;
  word_t base_q, base_d;

  word_t result_q, result_d;
  logic  valid_q, valid_d;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  word_t exp_sel;
  logic  accept;

  assign exp_sel = mode_i ? priv_q : pub_q;
  assign accept  = start_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= word_t'(1);
      pub_q  <= '0;
      priv_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODULUS:  mod_q  <= cfg_data_i;
        CFG_PUB_EXP:  pub_q  <= cfg_data_i;
        CFG_PRIV_EXP: priv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The sequencer feeds the shared multiplier: first value * 1 mod m to
  // reduce the base, then per exponent bit an optional res * base and a
  // base * base. Squaring stops once no higher exponent bit is left.
  always_comb begin
    state_d        = state_q;
    exp_d          = exp_q;
    res_d          = res_q;
    base_d         = base_q;
    result_d       = result_q;
    valid_d        = 1'b0;
    mm_req.start   = 1'b0;
    mm_req.op_a    = base_q;
    mm_req.op_b    = base_q;
    mm_req.modulus = mod_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          exp_d = exp_sel;
          // With modulus 1 every reduced result is 0, so the running
          // result starts there instead of at 1.
          res_d = (mod_q == word_t'(1)) ? '0 : word_t'(1);
          if (exp_sel == '0) begin
            result_d = word_t'(1);
            valid_d  = 1'b1;
          end else if (mod_q == '0) begin
            result_d = '0;
            valid_d  = 1'b1;
          end else begin
            mm_req.start = 1'b1;
            mm_req.op_a  = word_t'(1);
            mm_req.op_b  = value_i;
            state_d      = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_rsp.done) begin
          base_d  = mm_rsp.product;
          state_d = ST_BIT;
        end
      end
      ST_BIT: begin
        mm_req.start = 1'b1;
        if (exp_q[0]) begin
          mm_req.op_a = res_q;
          state_d     = ST_MUL;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_rsp.done) begin
          res_d = mm_rsp.product;
          if (exp_q[DataWidth-1:1] == '0) begin
            state_d = ST_DONE;
          end else begin
            mm_req.start = 1'b1;
            state_d      = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mm_rsp.done) begin
          base_d  = mm_rsp.product;
          exp_d   = {1'b0, exp_q[DataWidth-1:1]};
          state_d = ST_BIT;
        end
      end
      ST_DONE: begin
        result_d = res_q;
        valid_d  = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q    <= exp_d;
    res_q    <= res_d;
    base_q   <= base_d;
    result_q <= result_d;
  end

  rme_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign result_o       = result_q;
  assign result_valid_o = valid_q;

  // A result strobe only ever appears while the block is idle.
  `RME_ASSERT_SAME(a_strobe_idle, clk_i, rst_ni, result_valid_o, !busy_o)
  // A request that needs the multiplier makes the block busy.
  `RME_ASSERT_NEXT(a_start_busy, clk_i, rst_ni,
    start_i && !busy_o && (exp_sel != '0) && (mod_q != '0), busy_o)
  // The multiplier only finishes while the sequencer waits for it.
  `RME_ASSERT_SAME(a_done_waited, clk_i, rst_ni, mm_rsp.done,
    (state_q == ST_REDUCE) || (state_q == ST_MUL) || (state_q == ST_SQR))

endmodule

`default_nettype wire

@@ verif/tb_rsa_modular_exponentiation.sv @@
// Testbench for rsa_modular_exponentiation. It sends requests through the
// start/busy handshake and predicts each power with its own square-and-multiply
// routine. It checks every result strobe. Depends on rme_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_rsa_modular_exponentiation;
  import rme_pkg::*;

  // The port is two bits wide, so the fourth index exists but selects nothing.
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int unsigned MaxGap = 19;
  localparam int unsigned MaxReported = 10;
  // After the last expected result, wait longer than the longest request
  // takes, so that a stray strobe is caught.
  localparam int unsigned SettleCycles = 2200;
  localparam int unsigned RandomPhases = 14;
  localparam int unsigned RequestsPerPhase = 19;
  localparam word_t WordMax = '1;

  // One outstanding request: its operands, kept for messages, and the
  // power it must produce.
  typedef struct {
    logic  mode;
    word_t value;
    word_t power;
  } power_expect_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  logic  mode_i = 1'b0;
  word_t value_i = '0;
  logic  cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  word_t cfg_data_i = '0;
  logic  busy_o;
  word_t result_o;
  logic  result_valid_o;

  // The testbench keeps its own copy of the key registers.
  // It updates the copy on every write.
  word_t modulus_q = word_t'(1);
  word_t pub_exp_q = '0;
  word_t priv_exp_q = '0;

  power_expect_t pending_powers[$];
  int unsigned   mismatch_count = 0;
  bit            gaps_on = 1'b1;

  rsa_modular_exponentiation DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // This is right-to-left square and multiply with 64-bit intermediates.
  // Two reduced operands are below 2^31, so their product fits easily. An
  // exponent of zero gives 1 even for modulus 1, which is the unreduced case.
  // A zero modulus with a nonzero exponent gives 0.
  function automatic word_t modexp_predict(word_t base, word_t expo, word_t modulus);
    bit [63:0] m;
    bit [63:0] sq;
    bit [63:0] acc;
    if (expo == '0) return word_t'(1);
    if (modulus == '0) return '0;
    m = 64'(modulus);
    sq = 64'(base) % m;
    acc = 64'd1;
    for (int i = 0; i < DataWidth; i++) begin
      if (expo[i]) acc = ((acc % m) * sq) % m;
      sq = (sq * sq) % m;
    end
    return word_t'(acc % m);
  endfunction

  // Every strobe is compared with the oldest outstanding request. Outputs
  // are read at the rising edge, before the block's own updates land.
  always @(posedge clk_i) begin
    power_expect_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_powers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("result strobe with no request outstanding: result %0d", result_o);
      end else begin
        want = pending_powers.pop_front();
        if (result_o !== want.power) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("result mismatch: mode %0d value %0d expected %0d got %0d",
                     want.mode, want.value, want.power, result_o);
        end
      end
    end
  end

  // This task is entered and left at a falling edge. start_i stays high after
  // acceptance, so a following request with no gap goes back to back. If the
  // multiplier is needed, busy_o is high at the next edge and holds that request off.
  task automatic send_request(logic mode, word_t value);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(MaxGap, 0) : 0;
    if (gap != 0) begin
      start_i = 1'b0;
      repeat (gap) begin
        // While start is low the payload must not matter.
        mode_i = 1'($urandom);
        value_i = word_t'($urandom);
        @(negedge clk_i);
      end
    end
    start_i = 1'b1;
    mode_i = mode;
    value_i = value;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_powers.push_back('{mode, value,
      modexp_predict(value, mode ? priv_exp_q : pub_exp_q, modulus_q)});
    @(negedge clk_i);
  endtask

  // Each request gives exactly one result. An empty queue therefore means the
  // block has finished, and busy_o is already low by then.
  task automatic wait_idle();
    start_i = 1'b0;
    while (pending_powers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, word_t data);
    start_i = 1'b0;
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_idx_i = 2'($urandom);
    cfg_data_i = word_t'($urandom);
    case (idx)
      CFG_MODULUS:  modulus_q = data;
      CFG_PUB_EXP:  pub_exp_q = data;
      CFG_PRIV_EXP: priv_exp_q = data;
      default: ;
    endcase
  endtask

  task automatic set_key(word_t modulus, word_t pub_exp, word_t priv_exp);
    wait_idle();
    write_register(CFG_MODULUS, modulus);
    write_register(CFG_PUB_EXP, pub_exp);
    write_register(CFG_PRIV_EXP, priv_exp);
  endtask

  // An exponent has a random bit length; unless that is zero, its top bit is set.
  // Lengths are spread evenly, so short exponents are as common as long ones.
  function automatic word_t random_exponent();
    int unsigned len;
    len = $urandom_range(DataWidth, 0);
    if (len == 0) return '0;
    return word_t'(($urandom & ((32'd1 << len) - 32'd1)) | (32'd1 << (len - 1)));
  endfunction

  function automatic word_t random_modulus();
    case ($urandom_range(4, 0))
      0: return word_t'($urandom_range(16, 1));
      1: return word_t'($urandom_range(65535, 17));
      2: return WordMax;
      default: return word_t'($urandom) | word_t'(32'h4000_0000);
    endcase
  endfunction

  // Values cover the full range and values below the modulus. They also cover
  // the edges around the modulus, where the first reduction matters most.
  function automatic word_t random_value();
    case ($urandom_range(4, 0))
      0: return (modulus_q != '0) ? word_t'($urandom % modulus_q) : '0;
      1: return word_t'($urandom_range(1, 0));
      2: return modulus_q - word_t'($urandom_range(1, 0));
      default: return word_t'($urandom);
    endcase
  endfunction

  // After reset the modulus is 1 and both exponents are zero, so every
  // request must return 1.
  task automatic test_reset_state();
    send_request(1'b0, '0);
    send_request(1'b1, WordMax);
    send_request(1'b0, WordMax);
    send_request(1'b1, '0);
  endtask

  task automatic test_directed_extremes();
    // Largest modulus and exponents. A value equal to the modulus reduces to 0.
    set_key(WordMax, WordMax, WordMax);
    send_request(1'b0, '0);
    send_request(1'b1, word_t'(1));
    send_request(1'b0, WordMax);
    send_request(1'b1, WordMax - word_t'(1));
    // An exponent of one returns only the reduced base. A zero exponent
    // returns 1 whatever the value is.
    set_key(word_t'(1000003), word_t'(1), '0);
    send_request(1'b0, WordMax);
    send_request(1'b1, WordMax);
    // With modulus 1, a nonzero exponent collapses to 0, but a zero exponent
    // still gives 1.
    set_key(word_t'(1), word_t'(5), '0);
    send_request(1'b0, word_t'(12345));
    send_request(1'b1, word_t'(12345));
    // A zero modulus is outside the intended range but the port allows it.
    set_key('0, word_t'(7), '0);
    send_request(1'b0, word_t'(99));
    send_request(1'b1, word_t'(99));
    // A write to the unused index must leave the key untouched.
    set_key(word_t'(97), word_t'(2), word_t'(3));
    write_register(CfgUnused, word_t'(5));
    send_request(1'b0, word_t'(10));
    send_request(1'b1, word_t'(10));
    // Alternating bit patterns toggle every exponent and value bit.
    set_key(WordMax, word_t'(32'h2AAA_AAAA), word_t'(32'h5555_5555));
    send_request(1'b0, word_t'(32'h5555_5555));
    send_request(1'b1, word_t'(32'h2AAA_AAAA));
    set_key(word_t'(2), word_t'(3), word_t'(4));
    send_request(1'b0, word_t'(7));
  endtask

  // Each phase loads a fresh random key and then runs a batch of requests.
  // Every third phase sends with no gaps, so requests arrive back to back.
  task automatic test_random_keys();
    for (int p = 0; p < RandomPhases; p++) begin
      set_key(random_modulus(), random_exponent(), random_exponent());
      gaps_on = (p % 3) != 2;
      repeat (RequestsPerPhase) send_request(1'($urandom), random_value());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_directed_extremes();
    test_random_keys();
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_powers.size() == 0) begin
      $display("rsa_modular_exponentiation test passed");
    end else begin
      $display("rsa_modular_exponentiation test failed");
    end
    $finish;
  end

  // The slowest correct run, about 300 requests, takes roughly 1.2 ms.
  // This limit leaves a wide margin above that.
  initial begin
    #6_000_000;
    $display("rsa_modular_exponentiation test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rme_pkg.sv
rtl/core/rme_modmul.sv
rtl/core/rsa_modular_exponentiation.sv
verif/tb_rsa_modular_exponentiation.sv
